[design/weighted_error_norm_accumulator_assert.svh]
// Assertion macros for the weighted error norm accumulator checker.
// Self-contained; no other file is needed.
`ifndef WEIGHTED_ERROR_NORM_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_ERROR_NORM_ACCUMULATOR_ASSERT_SVH

// Consequent in the cycle after the antecedent, ignored while in reset.
`define WENA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("weighted_error_norm_accumulator: assertion failed");

// Consequent in the same cycle as the antecedent, ignored while in reset.
`define WENA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("weighted_error_norm_accumulator: assertion failed");

// Consequent in the cycle after the antecedent, checked in reset as well.
`define WENA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("weighted_error_norm_accumulator: assertion failed");

`endif

[design/wena_pkg.sv]
// Shared constants, types and helper functions of the weighted error norm accumulator.
// No dependencies.
package wena_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_RUN     = 16384;

   localparam int FIELD_BITS  = 16;
   localparam int VOL_IN_BITS = 16;
   localparam int NORM_BITS   = 16;
   localparam int STATUS_BITS = 2;
   localparam int ACC_BITS    = 64;
   localparam int VOL_BITS    = 31;

   localparam int MUL_A_BITS = 2 * SAMPLE_BITS;
   localparam int MUL_B_BITS = (SAMPLE_BITS > VOL_IN_BITS) ? SAMPLE_BITS : VOL_IN_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   localparam longint VOL_CAP_FULL  = longint'(MAX_RUN) * ((longint'(1) << VOL_IN_BITS) - 1);
   localparam longint VOL_FIELD_MAX = (longint'(1) << VOL_BITS) - 1;
   localparam logic [VOL_BITS:0] VOL_CAP =
      (VOL_BITS + 1)'((VOL_CAP_FULL > VOL_FIELD_MAX) ? VOL_FIELD_MAX : VOL_CAP_FULL);

   localparam int ROOT_BITS = ACC_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 1;
   localparam int SUB_BITS  = REM_BITS + 3;
   localparam int STEP_BITS = $clog2(ACC_BITS);

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_VOL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SATURATED = 2'd2;

   localparam logic OP_DIV  = 1'b0;
   localparam logic OP_SQRT = 1'b1;

   typedef struct packed {
      logic idle;
      logic done;
      logic last;
   } acc_stat_type;

   typedef struct packed {
      logic start;
      logic op;
   } ds_cmd_type;

   function automatic logic [NORM_BITS-1:0] clamp_norm(input logic [ACC_BITS-1:0] v);
      logic [NORM_BITS-1:0] r;
      if (v[ACC_BITS-1:NORM_BITS] != '0) begin
         r = '1;
      end else begin
         r = v[NORM_BITS-1:0];
      end
      return r;
   endfunction

endpackage

[design/wena_if.sv]
// Channel interfaces of the weighted error norm accumulator: sample input and norm result.
// Depends on wena_pkg.
interface wena_req_if;
   import wena_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] this_sample;
   logic signed [FIELD_BITS-1:0] other_sample;
   logic [VOL_IN_BITS-1:0]       cell_volume;
   logic                         last_of_variable;

   modport source (output valid, this_sample, other_sample, cell_volume, last_of_variable,
                   input ready);
   modport sink (input valid, this_sample, other_sample, cell_volume, last_of_variable,
                 output ready);
endinterface

interface wena_rsp_if;
   import wena_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [NORM_BITS-1:0]   l1_norm;
   logic [NORM_BITS-1:0]   l2_norm;
   logic [NORM_BITS-1:0]   linf_norm;
   logic [STATUS_BITS-1:0] norm_status;

   modport source (output valid, l1_norm, l2_norm, linf_norm, norm_status, input ready);
   modport sink (input valid, l1_norm, l2_norm, linf_norm, norm_status, output ready);
endinterface

[design/wena_accum.sv]
// Accumulator datapath: one shared multiplier and one shared saturating adder under a
// four-step sequence per transaction. Depends on wena_pkg.
module wena_accum (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic                                  clear,
   input  logic signed [wena_pkg::FIELD_BITS-1:0] this_sample,
   input  logic signed [wena_pkg::FIELD_BITS-1:0] other_sample,
   input  logic [wena_pkg::VOL_IN_BITS-1:0]      cell_volume,
   input  logic                                  last_of_variable,
   output wena_pkg::acc_stat_type                stat,
   output logic [wena_pkg::ACC_BITS-1:0]         abs_sum,
   output logic [wena_pkg::ACC_BITS-1:0]         square_sum,
   output logic [wena_pkg::VOL_BITS-1:0]         volume_sum,
   output logic [wena_pkg::NORM_BITS-1:0]        max_diff,
   output logic                                  saturated
);
   import wena_pkg::*;

   localparam logic [2:0] A_IDLE = 3'd0;
   localparam logic [2:0] A_MUL1 = 3'd1;
   localparam logic [2:0] A_MUL2 = 3'd2;
   localparam logic [2:0] A_MUL3 = 3'd3;
   localparam logic [2:0] A_ADD3 = 3'd4;

   logic [2:0]                   state_ff;
   logic [2:0]                   state_in;
   logic signed [SAMPLE_BITS-1:0] sa;
   logic signed [SAMPLE_BITS-1:0] sb;
   logic signed [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS-1:0]        d;
   logic [SAMPLE_BITS-1:0]        d_ff;
   logic [VOL_IN_BITS-1:0]        vol_ff;
   logic                          last_ff;
   logic [MUL_A_BITS-1:0]         mul_a;
   logic [MUL_B_BITS-1:0]         mul_b;
   logic [PROD_BITS-1:0]          prod_ff;
   logic [ACC_BITS-1:0]           add_sel;
   logic [ACC_BITS:0]             add_sum;
   logic [ACC_BITS-1:0]           add_sat;
   logic [VOL_BITS:0]             vol_next;
   logic [NORM_BITS-1:0]          d_clamped;
   logic [ACC_BITS-1:0]           abs_ff;
   logic [ACC_BITS-1:0]           sq_ff;
   logic [VOL_BITS-1:0]           volsum_ff;
   logic [NORM_BITS-1:0]          max_ff;
   logic                          sat_ff;

   assign sa   = SAMPLE_BITS'(this_sample);
   assign sb   = SAMPLE_BITS'(other_sample);
   assign diff = (SAMPLE_BITS + 1)'(sa) - (SAMPLE_BITS + 1)'(sb);
   assign d    = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);

   always_comb begin
      unique case (state_ff)
         A_IDLE:  state_in = take ? A_MUL1 : A_IDLE;
         A_MUL1:  state_in = A_MUL2;
         A_MUL2:  state_in = A_MUL3;
         A_MUL3:  state_in = A_ADD3;
         default: state_in = A_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         A_MUL1: begin
            mul_a = MUL_A_BITS'(d_ff);
            mul_b = MUL_B_BITS'(vol_ff);
         end
         A_MUL2: begin
            mul_a = MUL_A_BITS'(d_ff);
            mul_b = MUL_B_BITS'(d_ff);
         end
         default: begin
            mul_a = prod_ff[MUL_A_BITS-1:0];
            mul_b = MUL_B_BITS'(vol_ff);
         end
      endcase
   end

   assign add_sel   = (state_ff == A_MUL2) ? abs_ff : sq_ff;
   assign add_sum   = (ACC_BITS + 1)'(add_sel) + (ACC_BITS + 1)'(prod_ff);
   assign add_sat   = add_sum[ACC_BITS] ? '1 : add_sum[ACC_BITS-1:0];
   assign vol_next  = (VOL_BITS + 1)'(volsum_ff) + (VOL_BITS + 1)'(vol_ff);
   assign d_clamped = clamp_norm(ACC_BITS'(d_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         d_ff    <= d;
         vol_ff  <= cell_volume;
         last_ff <= last_of_variable;
      end
      prod_ff <= PROD_BITS'(mul_a * mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         abs_ff    <= '0;
         sq_ff     <= '0;
         volsum_ff <= '0;
         max_ff    <= '0;
         sat_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            A_MUL1: begin
               if (d_clamped > max_ff) begin
                  max_ff <= d_clamped;
               end
               if (vol_next > VOL_CAP) begin
                  volsum_ff <= VOL_BITS'(VOL_CAP);
                  sat_ff    <= 1'b1;
               end else begin
                  volsum_ff <= VOL_BITS'(vol_next);
               end
            end
            A_MUL2: begin
               abs_ff <= add_sat;
               if (add_sum[ACC_BITS]) begin
                  sat_ff <= 1'b1;
               end
            end
            A_ADD3: begin
               sq_ff <= add_sat;
               if (add_sum[ACC_BITS]) begin
                  sat_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.idle  = (state_ff == A_IDLE);
   assign stat.done  = (state_ff == A_ADD3);
   assign stat.last  = last_ff;
   assign abs_sum    = abs_ff;
   assign square_sum = sq_ff;
   assign volume_sum = volsum_ff;
   assign max_diff   = max_ff;
   assign saturated  = sat_ff;

endmodule

[design/wena_divsqrt.sv]
// Iterative divide and square root unit sharing one compare-subtract: one quotient bit
// or one root bit per cycle. Depends on wena_pkg.
module wena_divsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  wena_pkg::ds_cmd_type          cmd,
   input  logic [wena_pkg::ACC_BITS-1:0] operand,
   input  logic [wena_pkg::VOL_BITS-1:0] divisor,
   output logic                          done,
   output logic [wena_pkg::ACC_BITS-1:0] result
);
   import wena_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 op_ff;
   logic [STEP_BITS-1:0] count_ff;
   logic [ACC_BITS-1:0]  work_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [SUB_BITS-1:0]  sub_a;
   logic [SUB_BITS-1:0]  sub_b;
   logic [SUB_BITS-1:0]  sub_d;
   logic                 fits;
   logic [REM_BITS-1:0]  rem_in;

   always_comb begin
      if (op_ff == OP_DIV) begin
         sub_a = SUB_BITS'({rem_ff[ROOT_BITS-1:0], work_ff[ACC_BITS-1]});
         sub_b = SUB_BITS'(divisor);
      end else begin
         sub_a = SUB_BITS'({rem_ff, work_ff[ACC_BITS-1 -: 2]});
         sub_b = SUB_BITS'({root_ff, 2'b01});
      end
      sub_d  = sub_a - sub_b;
      fits   = ~sub_d[SUB_BITS-1];
      rem_in = fits ? sub_d[REM_BITS-1:0] : sub_a[REM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (count_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= cmd.op;
         work_ff  <= operand;
         rem_ff   <= '0;
         root_ff  <= '0;
         count_ff <= (cmd.op == OP_DIV) ? STEP_BITS'(ACC_BITS - 1) : STEP_BITS'(ROOT_BITS - 1);
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         count_ff <= count_ff - 1'b1;
         if (op_ff == OP_DIV) begin
            work_ff <= {work_ff[ACC_BITS-2:0], fits};
         end else begin
            work_ff <= {work_ff[ACC_BITS-3:0], 2'b00};
            root_ff <= {root_ff[ROOT_BITS-2:0], fits};
         end
      end
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_DIV) ? work_ff : ACC_BITS'(root_ff);

endmodule

[design/weighted_error_norm_accumulator.sv]
// Weighted error norm accumulator top level: run sequencer and result register.
// Depends on wena_pkg, wena_if, wena_accum and wena_divsqrt.
//
// Usage:
//   req_ch carries one sample pair with its cell volume per transaction; last_of_variable
//   marks the final pair of a run. rsp_ch carries one set of norms (L1, L2, Linf and
//   status) per run, valid/ready on both channels.
//   Each pair steps through the accumulator: the shared multiplier and adder form
//   |d|*vol, then d*d, then d*d*vol. req_ch.ready is low while the accumulator or
//   the run sequencer is busy. A run-ending pair then runs two restoring divisions of
//   the sums by the total volume and a square root of the second quotient, all in one
//   shared compare-subtract unit. A zero total volume skips the unit.
//   The result sits in an output register; while rsp_ch is stalled the block still takes
//   pairs of the next run and holds a further finished run until the register is free.
//   The accumulators clear as a run's result moves into the output register.
//   Synchronous reset clears the accumulators, the sequencer and rsp_ch.valid.
module weighted_error_norm_accumulator (
   input logic       clock,
   input logic       reset,
   wena_req_if.sink  req_ch,
   wena_rsp_if.source rsp_ch
);
   import wena_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_L1_GO  = 4'd2;
   localparam logic [3:0] S_L1_RUN = 4'd3;
   localparam logic [3:0] S_L2_GO  = 4'd4;
   localparam logic [3:0] S_L2_RUN = 4'd5;
   localparam logic [3:0] S_SQ_GO  = 4'd6;
   localparam logic [3:0] S_SQ_RUN = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   logic [3:0]             seq_ff;
   logic [3:0]             seq_in;
   logic                   take;
   logic                   emit_take;
   acc_stat_type           acc_stat;
   logic [ACC_BITS-1:0]    abs_sum;
   logic [ACC_BITS-1:0]    square_sum;
   logic [VOL_BITS-1:0]    volume_sum;
   logic [NORM_BITS-1:0]   max_diff;
   logic                   saturated;
   ds_cmd_type             ds_cmd;
   logic [ACC_BITS-1:0]    ds_operand;
   logic                   ds_done;
   logic [ACC_BITS-1:0]    ds_result;
   logic [NORM_BITS-1:0]   res_l1_ff;
   logic [NORM_BITS-1:0]   res_l2_ff;
   logic [NORM_BITS-1:0]   res_linf_ff;
   logic [STATUS_BITS-1:0] res_status_ff;
   logic                   rsp_valid_ff;
   logic [NORM_BITS-1:0]   rsp_l1_ff;
   logic [NORM_BITS-1:0]   rsp_l2_ff;
   logic [NORM_BITS-1:0]   rsp_linf_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   assign req_ch.ready = acc_stat.idle && (seq_ff == S_IDLE);
   assign take         = req_ch.valid && req_ch.ready;
   assign emit_take    = (seq_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   wena_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .clear            (emit_take),
      .this_sample      (req_ch.this_sample),
      .other_sample     (req_ch.other_sample),
      .cell_volume      (req_ch.cell_volume),
      .last_of_variable (req_ch.last_of_variable),
      .stat             (acc_stat),
      .abs_sum          (abs_sum),
      .square_sum       (square_sum),
      .volume_sum       (volume_sum),
      .max_diff         (max_diff),
      .saturated        (saturated)
   );

   always_comb begin
      ds_cmd.start = (seq_ff == S_L1_GO) || (seq_ff == S_L2_GO) || (seq_ff == S_SQ_GO);
      ds_cmd.op    = (seq_ff == S_SQ_GO) ? OP_SQRT : OP_DIV;
      unique case (seq_ff)
         S_L1_GO: ds_operand = abs_sum;
         S_L2_GO: ds_operand = square_sum;
         default: ds_operand = ds_result;
      endcase
   end

   wena_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ds_cmd),
      .operand (ds_operand),
      .divisor (volume_sum),
      .done    (ds_done),
      .result  (ds_result)
   );

   always_comb begin
      unique case (seq_ff)
         S_IDLE:   seq_in = (acc_stat.done && acc_stat.last) ? S_CHECK : S_IDLE;
         S_CHECK:  seq_in = (volume_sum == '0) ? S_EMIT : S_L1_GO;
         S_L1_GO:  seq_in = S_L1_RUN;
         S_L1_RUN: seq_in = ds_done ? S_L2_GO : S_L1_RUN;
         S_L2_GO:  seq_in = S_L2_RUN;
         S_L2_RUN: seq_in = ds_done ? S_SQ_GO : S_L2_RUN;
         S_SQ_GO:  seq_in = S_SQ_RUN;
         S_SQ_RUN: seq_in = ds_done ? S_EMIT : S_SQ_RUN;
         S_EMIT:   seq_in = emit_take ? S_IDLE : S_EMIT;
         default:  seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (emit_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ff == S_CHECK) begin
         res_l1_ff   <= '0;
         res_l2_ff   <= '0;
         res_linf_ff <= max_diff;
         if (volume_sum == '0) begin
            res_status_ff <= STATUS_ZERO_VOL;
         end else begin
            res_status_ff <= saturated ? STATUS_SATURATED : STATUS_OK;
         end
      end
      if ((seq_ff == S_L1_RUN) && ds_done) begin
         res_l1_ff <= clamp_norm(ds_result);
      end
      if ((seq_ff == S_SQ_RUN) && ds_done) begin
         res_l2_ff <= clamp_norm(ds_result);
      end
      if (emit_take) begin
         rsp_l1_ff     <= res_l1_ff;
         rsp_l2_ff     <= res_l2_ff;
         rsp_linf_ff   <= res_linf_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.l1_norm     = rsp_l1_ff;
   assign rsp_ch.l2_norm     = rsp_l2_ff;
   assign rsp_ch.linf_norm   = rsp_linf_ff;
   assign rsp_ch.norm_status = rsp_status_ff;

endmodule

[design/wena_checker.sv]
// Port-level checker for the weighted error norm accumulator, bound to the top level.
// Depends on wena_pkg and weighted_error_norm_accumulator_assert.svh.
`include "weighted_error_norm_accumulator_assert.svh"

module wena_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [wena_pkg::NORM_BITS-1:0]   l1_norm,
   input logic [wena_pkg::NORM_BITS-1:0]   l2_norm,
   input logic [wena_pkg::NORM_BITS-1:0]   linf_norm,
   input logic [wena_pkg::STATUS_BITS-1:0] norm_status
);
   import wena_pkg::*;

   logic [3*NORM_BITS+STATUS_BITS-1:0] rsp_payload;
   logic                               rsp_stalled;
   logic                               zero_vol_shown;

   assign rsp_payload    = {l1_norm, l2_norm, linf_norm, norm_status};
   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign zero_vol_shown = rsp_valid && (norm_status == STATUS_ZERO_VOL);

   `WENA_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, clock, reset, !rsp_valid)

   `WENA_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_stalled, rsp_valid)

   `WENA_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_stalled, $stable(rsp_payload))

   `WENA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   `WENA_ASSERT_SAME(a_zero_vol_norms, clock, reset, zero_vol_shown, ({l1_norm, l2_norm} == '0))

endmodule

bind weighted_error_norm_accumulator wena_checker u_wena_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .l1_norm     (rsp_ch.l1_norm),
   .l2_norm     (rsp_ch.l2_norm),
   .linf_norm   (rsp_ch.linf_norm),
   .norm_status (rsp_ch.norm_status)
);

[tb/tb_top.sv]
// Self-checking testbench for weighted_error_norm_accumulator: runs of sample pairs go in,
// and the L1, L2 and Linf norms of each run are checked against a predictor of its own.
// Depends on wena_pkg, wena_if and the weighted_error_norm_accumulator RTL.
module tb_top;
   import wena_pkg::*;

   localparam longint unsigned VOLUME_FULL  = longint'(MAX_RUN) * 65535;
   localparam longint unsigned VOLUME_LIMIT =
      (VOLUME_FULL > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : VOLUME_FULL;
   localparam int     RANDOM_PAIRS   = 1070;
   localparam int     LONG_RUN_PAIRS = 64;
   localparam int     SETTLE_CYCLES  = 200;
   localparam longint TIME_LIMIT     = 2_000_000;

   typedef struct packed {
      logic [NORM_BITS-1:0]   l1;
      logic [NORM_BITS-1:0]   l2;
      logic [NORM_BITS-1:0]   linf;
      logic [STATUS_BITS-1:0] status;
   } norm_set_type;

   logic clock;
   logic reset;

   wena_req_if req_ch();
   wena_rsp_if rsp_ch();

   weighted_error_norm_accumulator dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   longint unsigned      run_abs_sum;
   longint unsigned      run_square_sum;
   longint unsigned      run_volume;
   logic [NORM_BITS-1:0] run_peak;
   bit                   run_saturated;

   norm_set_type pending_norms[$];
   int        error_count   = 0;
   int        pairs_sent    = 0;
   int        runs_checked  = 0;
   bit        sender_idles   = 1'b1;
   bit        receiver_idles = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIME_LIMIT);
      $display("Timeout with %0d runs still pending", pending_norms.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic void clear_run();
      run_abs_sum    = 0;
      run_square_sum = 0;
      run_volume     = 0;
      run_peak       = '0;
      run_saturated  = 1'b0;
   endfunction

   function automatic logic [NORM_BITS-1:0] to_norm(input longint unsigned v);
      return (v > 64'hFFFF) ? '1 : NORM_BITS'(v);
   endfunction

   function automatic longint unsigned add_sticky(input longint unsigned a,
                                                  input longint unsigned b);
      longint unsigned s;
      s = a + b;
      if (s < a) begin
         run_saturated = 1'b1;
         s = '1;
      end
      return s;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // fold one pair into the run; on a run-ending pair give the norms and clear
   function automatic bit fold_pair(input logic signed [FIELD_BITS-1:0] ref_s,
                                    input logic signed [FIELD_BITS-1:0] cmp_s,
                                    input logic [VOL_IN_BITS-1:0] vol,
                                    input logic ends_run,
                                    output norm_set_type norms);
      longint          a;
      longint          b;
      longint unsigned d;
      longint unsigned w;
      longint unsigned nv;
      a = (longint'(ref_s) <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
      b = (longint'(cmp_s) <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
      d = (a >= b) ? a - b : b - a;
      w = vol;
      norms = '0;
      run_abs_sum    = add_sticky(run_abs_sum, d * w);
      run_square_sum = add_sticky(run_square_sum, d * d * w);
      if (to_norm(d) > run_peak) begin
         run_peak = to_norm(d);
      end
      nv = run_volume + w;
      if (nv > VOLUME_LIMIT) begin
         nv = VOLUME_LIMIT;
         run_saturated = 1'b1;
      end
      run_volume = nv;
      if (!ends_run) begin
         return 1'b0;
      end
      norms.linf = run_peak;
      if (run_volume == 0) begin
         norms.status = STATUS_ZERO_VOL;
      end else begin
         norms.l1     = to_norm(run_abs_sum / run_volume);
         norms.l2     = to_norm(floor_root(run_square_sum / run_volume));
         norms.status = run_saturated ? STATUS_SATURATED : STATUS_OK;
      end
      clear_run();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_pair(input logic signed [FIELD_BITS-1:0] ref_s,
                            input logic signed [FIELD_BITS-1:0] cmp_s,
                            input logic [VOL_IN_BITS-1:0] vol,
                            input logic ends_run);
      norm_set_type norms;
      int        gap;
      req_ch.valid            <= 1'b1;
      req_ch.this_sample      <= ref_s;
      req_ch.other_sample     <= cmp_s;
      req_ch.cell_volume      <= vol;
      req_ch.last_of_variable <= ends_run;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (fold_pair(ref_s, cmp_s, vol, ends_run, norms)) begin
         pending_norms.push_back(norms);
      end
      pairs_sent++;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : norm_check
      norm_set_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_norms.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction l1=%0d l2=%0d linf=%0d st=%0d",
                            rsp_ch.l1_norm, rsp_ch.l2_norm, rsp_ch.linf_norm,
                            rsp_ch.norm_status));
         end else begin
            want = pending_norms.pop_front();
            if (rsp_ch.l1_norm !== want.l1) begin
               report_mismatch($sformatf("run %0d l1_norm got %0d want %0d",
                               runs_checked, rsp_ch.l1_norm, want.l1));
            end
            if (rsp_ch.l2_norm !== want.l2) begin
               report_mismatch($sformatf("run %0d l2_norm got %0d want %0d",
                               runs_checked, rsp_ch.l2_norm, want.l2));
            end
            if (rsp_ch.linf_norm !== want.linf) begin
               report_mismatch($sformatf("run %0d linf_norm got %0d want %0d",
                               runs_checked, rsp_ch.linf_norm, want.linf));
            end
            if (rsp_ch.norm_status !== want.status) begin
               report_mismatch($sformatf("run %0d norm_status got %0d want %0d",
                               runs_checked, rsp_ch.norm_status, want.status));
            end
         end
         runs_checked++;
      end
   end

   initial begin
      int burst;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         burst = $urandom_range(1, 24);
         repeat (burst) @(posedge clock);
         gap = receiver_idles ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic test_extremes();
      send_pair(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 16'd1, 1'b1);
      send_pair(16'sh0000, 16'shFFFF, 16'd1, 1'b0);
      send_pair(16'shFFFF, 16'sh0000, 16'd2, 1'b0);
      send_pair(16'sh1234, 16'shEDCC, 16'd300, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 16'hFFFF, 1'b1);
      // truncated quotients on both norms
      send_pair(16'sd10, 16'sd0, 16'd3, 1'b0);
      send_pair(16'sd0, 16'sd7, 16'd4, 1'b1);
      send_pair(16'sh5555, 16'shAAAA, 16'hAAAA, 1'b0);
      send_pair(16'shAAAA, 16'sh5555, 16'h5555, 1'b1);
   endtask

   task automatic test_zero_volume();
      send_pair(16'sd0, 16'sd0, 16'd0, 1'b1);
      send_pair(16'sd100, -16'sd100, 16'd0, 1'b0);
      send_pair(16'sh7FFF, 16'sh8000, 16'd0, 1'b1);
      // zero-volume pairs still raise the peak of a weighted run
      send_pair(16'sh7FFF, 16'sd0, 16'd0, 1'b0);
      send_pair(16'sd1, 16'sd0, 16'd5, 1'b1);
   endtask

   task automatic test_long_run();
      sender_idles = 1'b0;
      for (int i = 0; i < LONG_RUN_PAIRS; i++) begin
         send_pair(16'($urandom), 16'($urandom), 16'hFFFF, 1'b0);
      end
      send_pair(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1);
      sender_idles = 1'b1;
   endtask

   task automatic test_random_runs();
      int                            sent;
      int                            run_len;
      int                            mode;
      bit                            zero_vol_run;
      logic signed [FIELD_BITS-1:0]  ref_s;
      logic signed [FIELD_BITS-1:0]  cmp_s;
      logic [VOL_IN_BITS-1:0]        vol;
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         if ($urandom_range(0, 15) == 0) begin
            mode = $urandom_range(0, 3);
            sender_idles   = mode[0];
            receiver_idles = mode[1];
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                               : $urandom_range(1, 12);
         zero_vol_run = ($urandom_range(0, 11) == 0);
         for (int i = 0; i < run_len; i++) begin
            ref_s = 16'($urandom);
            case ($urandom_range(0, 3))
               0: cmp_s = 16'($urandom);
               1: cmp_s = ref_s + 16'($urandom_range(0, 64)) - 16'sd32;
               2: cmp_s = ref_s;
               default: begin
                  ref_s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  cmp_s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               end
            endcase
            case ($urandom_range(0, 7))
               0: vol = 16'd0;
               1, 2: vol = 16'($urandom_range(1, 16));
               3: vol = 16'hFFFF;
               default: vol = 16'($urandom);
            endcase
            if (zero_vol_run) begin
               vol = 16'd0;
            end
            send_pair(ref_s, cmp_s, vol, i == run_len - 1);
            sent++;
         end
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.this_sample      <= '0;
      req_ch.other_sample     <= '0;
      req_ch.cell_volume      <= '0;
      req_ch.last_of_variable <= 1'b0;
      clear_run();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_zero_volume();
      test_long_run();
      test_random_runs();
      req_ch.valid <= 1'b0;

      while (pending_norms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d sample pairs and checked %0d runs of norms,", pairs_sent,
               runs_checked);
      $display("covering extreme samples, zero total volume and long full-volume runs.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
